### rtl/bsl_pkg.sv
package bsl_pkg;

    localparam logic [4:0] TEST_TICKS   = 5'd20;
    localparam logic [2:0] FLASH_TICKS  = 3'd4;
    localparam logic [7:0] BRIGHT       = 8'd45;
    localparam logic [7:0] DIM          = 8'd35;
    localparam logic [7:0] MAGENTA_BLUE = 8'd28;
    localparam logic [2:0] BLINK_HALF   = 3'd4;

    localparam logic [4:0] TEST_RED_ABOVE   = 5'd15;
    localparam logic [4:0] TEST_GREEN_ABOVE = 5'd10;
    localparam logic [4:0] TEST_BLUE_ABOVE  = 5'd5;

    localparam logic [15:0] HOLD_MAX = 16'hFFFF;

    localparam logic [2:0] REG_LONG_PRESS      = 3'd0;
    localparam logic [2:0] REG_VERY_LONG_PRESS = 3'd1;
    localparam logic [2:0] REG_RECONNECT       = 3'd2;
    localparam logic [2:0] REG_MAINTAIN        = 3'd3;
    localparam logic [2:0] REG_POLL            = 3'd4;

    typedef enum logic [1:0] {
        EV_NONE    = 2'd0,
        EV_TRIGGER = 2'd1,
        EV_PAIR    = 2'd2,
        EV_FORGET  = 2'd3
    } t_event;

    typedef struct packed {
        logic [15:0] long_press_ticks;
        logic [15:0] very_long_press_ticks;
        logic [7:0]  reconnect_period;
        logic [7:0]  maintain_period;
        logic [7:0]  poll_period;
    } t_cfg;

    typedef struct packed {
        logic [15:0] hold_count;
        logic [4:0]  test_count;
        logic [2:0]  flash_count;
        logic [2:0]  blink_phase;
        logic [7:0]  reconnect_count;
        logic [7:0]  maintain_count;
        logic [7:0]  poll_count;
    } t_state;

    typedef struct packed {
        logic button_down;
        logic test_request;
        logic flash_request;
        logic pairing_active;
        logic link_connected;
        logic previously_paired;
    } t_item;

    typedef struct packed {
        logic       poll_pulse;
        logic       maintain_pulse;
        logic       reconnect_pulse;
        t_event     button_event;
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } t_result;

    typedef struct packed {
        logic       fire;
        logic [7:0] count;
    } t_period;

endpackage

### rtl/bsl_tick.sv
module bsl_tick
    import bsl_pkg::*;
(
    input  t_cfg    i_cfg,
    input  t_state  i_state,
    input  t_item   i_item,
    output t_state  o_state,
    output t_result o_result
);

    function automatic t_period period_step(input logic [7:0] count, input logic [7:0] period);
        t_period    res;
        logic [8:0] nxt;
        nxt = {1'b0, count} + 9'd1;
        if (nxt >= {1'b0, period}) begin
            res.fire  = 1'b1;
            res.count = 8'd0;
        end else begin
            res.fire  = 1'b0;
            res.count = nxt[7:0];
        end
        return res;
    endfunction

    logic [4:0] test_cnt;
    logic [2:0] flash_cnt;
    logic [2:0] phase_inc;
    t_period    rc_step;
    t_period    mt_step;
    t_period    pl_step;

    assign test_cnt  = i_item.test_request  ? TEST_TICKS  : i_state.test_count;
    assign flash_cnt = i_item.flash_request ? FLASH_TICKS : i_state.flash_count;
    assign phase_inc = i_state.blink_phase + 3'd1;

    assign rc_step = period_step(i_state.reconnect_count, i_cfg.reconnect_period);
    assign mt_step = period_step(i_state.maintain_count, i_cfg.maintain_period);
    assign pl_step = period_step(i_state.poll_count, i_cfg.poll_period);

    always_comb begin
        o_state  = i_state;
        o_result = '0;

        o_state.test_count  = test_cnt;
        o_state.flash_count = flash_cnt;

        if (i_item.button_down) begin
            if (i_state.hold_count != HOLD_MAX) begin
                o_state.hold_count = i_state.hold_count + 16'd1;
            end
        end else if (i_state.hold_count != 16'd0) begin
            if (i_state.hold_count >= i_cfg.very_long_press_ticks) begin
                o_result.button_event = EV_FORGET;
            end else if (i_state.hold_count >= i_cfg.long_press_ticks) begin
                o_result.button_event = EV_PAIR;
            end else begin
                o_result.button_event = EV_TRIGGER;
            end
            o_state.hold_count = 16'd0;
        end

        if (test_cnt != 5'd0) begin
            if (test_cnt > TEST_RED_ABOVE) begin
                o_result.red = BRIGHT;
            end else if (test_cnt > TEST_GREEN_ABOVE) begin
                o_result.green = BRIGHT;
            end else if (test_cnt > TEST_BLUE_ABOVE) begin
                o_result.blue = BRIGHT;
            end else begin
                o_result.red  = BRIGHT;
                o_result.blue = MAGENTA_BLUE;
            end
            o_state.test_count = test_cnt - 5'd1;
        end else if (flash_cnt != 3'd0) begin
            o_result.red        = BRIGHT;
            o_result.blue       = MAGENTA_BLUE;
            o_state.flash_count = flash_cnt - 3'd1;
        end else if (i_item.pairing_active) begin
            o_state.blink_phase = phase_inc;
            o_result.blue       = (phase_inc < BLINK_HALF) ? BRIGHT : 8'd0;
        end else if (i_item.link_connected) begin
            o_state.blink_phase = 3'd0;
            o_result.green      = DIM;
        end else begin
            o_state.blink_phase = 3'd0;
            o_result.red        = DIM;
        end

        o_state.reconnect_count  = rc_step.count;
        o_state.maintain_count   = mt_step.count;
        o_state.poll_count       = pl_step.count;
        o_result.reconnect_pulse = rc_step.fire & i_item.previously_paired
                                   & ~i_item.link_connected;
        o_result.maintain_pulse  = mt_step.fire;
        o_result.poll_pulse      = pl_step.fire;
    end

endmodule

### rtl/button_and_status_led_ticker.sv
// Channel     | Direction | Payload
// ------------+-----------+------------------------------------------------------
// s_axis      | in        | tick request: button, test, flash, pairing, link, paired
// m_axis      | out       | status: red, green, blue, button event, three pulses
// APB         | in/out    | five configuration registers at byte address 4*i
//
// One request is accepted per cycle; its result appears in the output register
// on the next cycle, and the tick update is a single pass through the counter
// and colour logic. Synchronous active-low reset clears all counters, loads the
// register defaults and empties the output register. While the output is
// stalled with a result held, input is accepted only when that result is taken.
module button_and_status_led_ticker
    import bsl_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // [0] button_down, [1] test_request, [2] flash_request, [3] pairing_active,
    // [4] link_connected, [5] previously_paired, [7:6] zero
    input  logic [7:0]  i_s_axis_tdata,

    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // [7:0] red, [15:8] green, [23:16] blue, [25:24] button_event,
    // [26] reconnect_pulse, [27] maintain_pulse, [28] poll_pulse, [31:29] zero
    output logic [31:0] o_m_axis_tdata,

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    t_cfg    r_cfg;
    t_state  r_state;
    t_state  n_state;
    t_result r_result;
    t_result n_result;
    t_item   in_item;
    logic    r_out_valid;
    logic    in_accept;
    logic    cfg_write;

    assign in_item = '{
        button_down:       i_s_axis_tdata[0],
        test_request:      i_s_axis_tdata[1],
        flash_request:     i_s_axis_tdata[2],
        pairing_active:    i_s_axis_tdata[3],
        link_connected:    i_s_axis_tdata[4],
        previously_paired: i_s_axis_tdata[5]
    };

    assign o_s_axis_tready = ~r_out_valid | i_m_axis_tready;
    assign in_accept       = i_s_axis_tvalid & o_s_axis_tready;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {3'b000, r_result};

    assign pready    = 1'b1;
    assign cfg_write = psel & penable & pwrite & pready;

    bsl_tick u_tick (
        .i_cfg    (r_cfg),
        .i_state  (r_state),
        .i_item   (in_item),
        .o_state  (n_state),
        .o_result (n_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.long_press_ticks      <= 16'd30;
            r_cfg.very_long_press_ticks <= 16'd100;
            r_cfg.reconnect_period      <= 8'd200;
            r_cfg.maintain_period       <= 8'd100;
            r_cfg.poll_period           <= 8'd20;
        end else if (cfg_write) begin
            case (paddr[4:2])
                REG_LONG_PRESS:      r_cfg.long_press_ticks      <= pwdata[15:0];
                REG_VERY_LONG_PRESS: r_cfg.very_long_press_ticks <= pwdata[15:0];
                REG_RECONNECT:       r_cfg.reconnect_period      <= pwdata[7:0];
                REG_MAINTAIN:        r_cfg.maintain_period       <= pwdata[7:0];
                REG_POLL:            r_cfg.poll_period           <= pwdata[7:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (paddr[4:2])
            REG_LONG_PRESS:      prdata = {16'd0, r_cfg.long_press_ticks};
            REG_VERY_LONG_PRESS: prdata = {16'd0, r_cfg.very_long_press_ticks};
            REG_RECONNECT:       prdata = {24'd0, r_cfg.reconnect_period};
            REG_MAINTAIN:        prdata = {24'd0, r_cfg.maintain_period};
            REG_POLL:            prdata = {24'd0, r_cfg.poll_period};
            default:             prdata = 32'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_accept) begin
                r_state     <= n_state;
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_result <= n_result;
        end
    end

`ifndef NO_ASSERTIONS
    a_accept_fills_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> o_m_axis_tvalid)
        else $error("accepted request did not produce a result");

    a_state_holds_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !in_accept |=> $stable(r_state))
        else $error("tick state changed without an accepted request");

    a_test_counts_down: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && !i_s_axis_tdata[1] && r_state.test_count != 5'd0)
        |=> r_state.test_count == $past(r_state.test_count) - 5'd1)
        else $error("test sequence counter did not step down");

    a_counters_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.test_count <= TEST_TICKS && r_state.flash_count <= FLASH_TICKS)
        else $error("sequence counter above its start value");
`endif

endmodule
